// ===== rtl/mtfo_pkg.sv =====
// Shared types for the first-output generator pipeline.
`timescale 1ns / 1ps

package mtfo_pkg;

  // One item as it moves down the initialization chain
  typedef struct packed {
    logic [31:0] word;   // latest initialization word
    logic [31:0] y;      // twist input: seed top bit, low 31 bits of word 1
  } mtfo_lane_t;

  // One finished result
  typedef struct packed {
    logic [31:0] first_word;
    logic        hit;
  } mtfo_result_t;

endpackage

// ===== rtl/mtfo_seed_if.sv =====
// Valid/ready channel that carries one seed per item.
`timescale 1ns / 1ps

interface mtfo_seed_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

// ===== rtl/mtfo_word_if.sv =====
// Valid/ready channel that carries one tempered word and its hit flag per item.
`timescale 1ns / 1ps

interface mtfo_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_word;
  logic        hit;

  modport source (output valid, output first_word, output hit, input ready);
  modport sink (input valid, input first_word, input hit, output ready);
endinterface

// ===== rtl/mtfo_init_stage.sv =====
// One step of the initialization recurrence, registered.
`timescale 1ns / 1ps

module mtfo_init_stage
  import mtfo_pkg::*;
#(
  parameter int STEP = 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       prev_valid,
  input  mtfo_lane_t prev_lane,
  output logic       valid,
  output mtfo_lane_t lane
);

  localparam logic [31:0] INIT_MULT = 32'd1812433253;
  localparam logic [31:0] STEP_W    = 32'(STEP);

  logic [31:0] mixed;
  logic [31:0] word_next;
  logic [31:0] y_next;

  // w[k] = mult * (w ^ (w >> 30)) + k, mod 2^32
  always_comb begin
    mixed     = prev_lane.word ^ (prev_lane.word >> 30);
    word_next = INIT_MULT * mixed + STEP_W;
    // first step builds the twist input from seed top bit and word 1
    if (STEP == 1) begin
      y_next = {prev_lane.y[31], word_next[30:0]};
    end else begin
      y_next = prev_lane.y;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= prev_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      lane.word <= word_next;
      lane.y    <= y_next;
    end
  end

endmodule

// ===== rtl/mtfo_finish.sv =====
// Twist, tempering and divisible-by-ten flag over three register stages.
`timescale 1ns / 1ps

module mtfo_finish
  import mtfo_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic         prev_valid,
  input  mtfo_lane_t   prev_lane,
  output logic         valid,
  output mtfo_result_t result
);

  localparam logic [31:0] TWIST_XOR = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc60000;

  logic [2:0]  stage_valid;
  logic [31:0] temp_word;     // stage 1
  logic [31:0] sum_word;      // stage 2
  logic [6:0]  nib_sum;       // stage 2

  logic [31:0] twisted;
  logic [31:0] tempered;
  logic [6:0]  nib_sum_next;
  logic [4:0]  fold;
  logic        mult5;

  // twist then temper
  always_comb begin
    twisted  = prev_lane.word ^ (prev_lane.y >> 1) ^ (prev_lane.y[0] ? TWIST_XOR : 32'd0);
    tempered = twisted ^ (twisted >> 11);
    tempered = tempered ^ ((tempered << 7) & TEMPER_B);
    tempered = tempered ^ ((tempered << 15) & TEMPER_C);
    tempered = tempered ^ (tempered >> 18);
  end

  // 16 = 1 mod 5, so the nibble sum keeps the residue mod 5
  always_comb begin
    nib_sum_next = '0;
    for (int i = 0; i < 8; i++) begin
      nib_sum_next = nib_sum_next + 7'(temp_word[4*i +: 4]);
    end
  end

  // fold once more, then check the few multiples of five that fit
  always_comb begin
    fold  = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
    mult5 = (fold == 5'd0) || (fold == 5'd5) || (fold == 5'd10) ||
            (fold == 5'd15) || (fold == 5'd20);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (adv) begin
      stage_valid <= {stage_valid[1:0], prev_valid};
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      temp_word         <= tempered;
      sum_word          <= temp_word;
      nib_sum           <= nib_sum_next;
      result.first_word <= sum_word;
      result.hit        <= mult5 & ~sum_word[0];
    end
  end

  assign valid = stage_valid[2];

endmodule

// ===== rtl/mtfo_out_buf.sv =====
// Output register plus skid register; holds the pipeline while both are full.
`timescale 1ns / 1ps

module mtfo_out_buf
  import mtfo_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  output logic         adv,
  input  logic         pipe_valid,
  input  mtfo_result_t pipe_result,
  mtfo_word_if.source  results
);

  logic         out_valid;
  mtfo_result_t out_data;
  logic         skid_valid;
  mtfo_result_t skid_data;
  logic         take;
  logic         arrive;

  // pipeline moves whenever the skid slot is free
  assign adv    = ~skid_valid;
  assign take   = out_valid & results.ready;
  assign arrive = pipe_valid & adv;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= arrive;
      end
    end else if (!out_valid) begin
      out_valid <= arrive;
    end else if (arrive) begin
      skid_valid <= 1'b1;
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (arrive) begin
        out_data <= pipe_result;
      end
    end else if (!out_valid) begin
      if (arrive) begin
        out_data <= pipe_result;
      end
    end else if (arrive) begin
      skid_data <= pipe_result;
    end
  end

  assign results.valid      = out_valid;
  assign results.first_word = out_data.first_word;
  assign results.hit        = out_data.hit;

endmodule

// ===== rtl/mt19937_seed_first_output_mod10_top.sv =====
// Top level: seed in, first tempered MT19937 word and divisible-by-ten flag out.
// Takes one seed per clock and returns one result per clock, in order, while
// results does not stall. The chain has one registered multiply-add stage per
// initialization word (TWIST_OFFSET stages), then three stages for
// twist/tempering, nibble sum and the flag, then an output register. The whole
// chain advances together; a skid register behind the output register absorbs
// the one item in flight when the sink stops, so seeds.ready drops once that
// item lands in the skid register and rises again as soon as the skid item
// moves out. Reset clears only valid bits.
`timescale 1ns / 1ps

module mt19937_seed_first_output_mod10_top
  import mtfo_pkg::*;
#(
  parameter int TWIST_OFFSET = 397
) (
  input  logic        clk,
  input  logic        rst,
  mtfo_seed_if.sink   seeds,
  mtfo_word_if.source results
);

  logic                  adv;
  logic [TWIST_OFFSET:0] lane_valid;
  mtfo_lane_t            lanes [TWIST_OFFSET+1];
  logic                  fin_valid;
  mtfo_result_t          fin_result;

  // entry: the seed is word 0 and supplies the twist top bit
  assign seeds.ready   = adv;
  assign lane_valid[0] = seeds.valid;
  assign lanes[0]      = '{word: seeds.seed, y: seeds.seed};

  // initialization recurrence, one stage per word
  for (genvar k = 1; k <= TWIST_OFFSET; k++) begin : g_init
    mtfo_init_stage #(
      .STEP(k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .prev_valid(lane_valid[k-1]),
      .prev_lane (lanes[k-1]),
      .valid     (lane_valid[k]),
      .lane      (lanes[k])
    );
  end

  // twist, tempering, flag
  mtfo_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .prev_valid(lane_valid[TWIST_OFFSET]),
    .prev_lane (lanes[TWIST_OFFSET]),
    .valid     (fin_valid),
    .result    (fin_result)
  );

  // output register and skid
  mtfo_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .pipe_valid (fin_valid),
    .pipe_result(fin_result),
    .results    (results)
  );

endmodule
